/* rtl/cfr_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the command frame receiver
// no dependencies

package cfr_pkg;

    // header and command codes
    localparam logic [7:0] HDR0       = 8'hAA;
    localparam logic [7:0] HDR1       = 8'hAF;
    localparam logic [7:0] CMD_GAINS  = 8'h12;
    localparam logic [7:0] CMD_RETURN = 8'h02;

    // acknowledge frame constants
    localparam logic [7:0] ACK_ID  = 8'hF0;
    localparam logic [7:0] ACK_LEN = 8'h03;
    localparam logic [7:0] ACK_TAG = 8'hBA;
    localparam logic [7:0] ACK_PAD = 8'h00;

    // frame length limits, as position of the checksum byte
    localparam logic [7:0] MIN_END_POS   = 8'd4;
    localparam logic [7:0] GAIN_END_POS  = 8'd10;
    localparam logic [7:0] PAYLOAD_FIRST = 8'd4;
    localparam logic [7:0] POS_MAX       = 8'd255;

    localparam int NUM_GAINS   = 3;
    localparam int PAYLOAD_LEN = 6;

    typedef logic [2:0] ack_idx_t;
    localparam ack_idx_t ACK_LAST_IDX = 3'd7;

    // the six fixed acknowledge bytes fold into one constant for the trailer
    localparam logic [10:0] ACK_HEAD_SUM = 11'(HDR0) + 11'(HDR0) + 11'(ACK_ID)
                                         + 11'(ACK_LEN) + 11'(ACK_TAG) + 11'(ACK_PAD);

    typedef logic [2:0] payload_idx_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic [7:0]         tx_byte;
        logic               tx_last;
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic               return_request;
    } ack_item_t;

    // what the frame checker hands the acknowledge sender
    typedef struct packed {
        logic [7:0]         rx_sum;
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic               return_request;
    } ack_req_t;

    function automatic logic [7:0] ack_byte(input ack_idx_t idx, input logic [7:0] rx_sum);
        logic [7:0] b;
        case (idx)
            3'd0:    b = HDR0;
            3'd1:    b = HDR0;
            3'd2:    b = ACK_ID;
            3'd3:    b = ACK_LEN;
            3'd4:    b = ACK_TAG;
            3'd5:    b = ACK_PAD;
            3'd6:    b = rx_sum;
            default: b = rx_sum + ACK_HEAD_SUM[7:0];
        endcase
        return b;
    endfunction

endpackage

/* rtl/command_frame_receiver_with_ack_unit.sv */
`timescale 1ns / 1ps
// top level of the command frame receiver with acknowledge
// depends on cfr_pkg, cfr_frame and cfr_ack_tx
//
// rx channel: one received byte per request, frame_end set on the frame's
// checksum byte. every byte before it is summed mod 256 and compared with it;
// bytes 0 and 1 must be AA AF, byte 2 is the command, bytes 4..9 the payload.
// a good frame of at least 5 bytes loads gains (command 12h, at least 11
// bytes) or sets the sticky return flag (command 02h), and is answered on the
// ack channel by eight requests AA AA F0 03 BA 00 <sum> <trailer>, each also
// carrying the gains and flag as they stand after that frame. bad frames give
// nothing on the ack channel.
// a byte is first held in the input register, then checked; once the ack
// buffer is free, the frame_end byte loads the ack sender, whose first byte
// is registered and then valid.
// throughput: one rx byte per cycle; ack bytes go out one per cycle while
// ack_ready is high. a frame_end byte waits in the input register while the
// previous acknowledge is still draining, set by the single eight-byte ack
// buffer; other bytes keep flowing, also when the ack side stalls.
// reset: frame state cleared, header flag set, gains zero, return flag clear.

module command_frame_receiver_with_ack_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  cfr_pkg::rx_item_t  rx_item,
    output logic               ack_valid,
    input  logic               ack_ready,
    output cfr_pkg::ack_item_t ack_item
);
    import cfr_pkg::*;

    logic     hold_valid_reg, hold_valid_next;
    rx_item_t hold_item_reg;
    logic     step;
    logic     tx_free;
    logic     ack_fire;
    ack_req_t ack_req;

    // a checksum byte needs the ack buffer free before it is processed
    assign step     = hold_valid_reg && (!hold_item_reg.frame_end || tx_free);
    assign rx_ready = !hold_valid_reg || step;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (rx_ready)
            hold_valid_next = rx_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
            hold_item_reg <= rx_item;
    end

    cfr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (hold_item_reg.rx_byte),
        .frame_end (hold_item_reg.frame_end),
        .ack_fire  (ack_fire),
        .ack_req   (ack_req)
    );

    cfr_ack_tx u_ack_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ack_fire),
        .req       (ack_req),
        .free      (tx_free),
        .ack_valid (ack_valid),
        .ack_ready (ack_ready),
        .ack_item  (ack_item)
    );

    // an acknowledge only starts when the sender can take it
    a_fire_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ack_fire |-> (hold_valid_reg && hold_item_reg.frame_end && tx_free))
        else $error("acknowledge started while sender busy");

    // a non-final ack byte taken is followed by another ack byte
    a_ack_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (ack_valid && ack_ready && !ack_item.tx_last) |=> ack_valid)
        else $error("acknowledge frame cut short");

    // a held checksum byte is not dropped while the sender drains
    a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && hold_item_reg.frame_end && !tx_free) |-> !rx_ready)
        else $error("checksum byte overwritten while ack pending");

    // the trailer always follows the received sum by the fixed header sum
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (ack_valid && ack_ready && !ack_item.tx_last && $past(ack_valid && ack_ready))
        |=> (!ack_item.tx_last || ack_item.tx_byte == ($past(ack_item.tx_byte)
            + ACK_HEAD_SUM[7:0])))
        else $error("acknowledge trailer mismatch");

endmodule

/* rtl/cfr_frame.sv */
`timescale 1ns / 1ps
// frame checker: running sum, header check, command and payload capture,
// gain and return-flag registers; depends on cfr_pkg

module cfr_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              frame_end,
    output logic              ack_fire,
    output cfr_pkg::ack_req_t ack_req
);
    import cfr_pkg::*;

    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         sum_reg, sum_next;
    logic               hdr_ok_reg, hdr_ok_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic signed [15:0] gain_reg  [NUM_GAINS];
    logic signed [15:0] gain_next [NUM_GAINS];
    logic               ret_reg, ret_next;
    logic [7:0]         payload_reg [PAYLOAD_LEN];
    logic               pl_wr;
    logic [7:0]         pl_off;
    payload_idx_t       pl_idx;
    logic               frame_ok;

    assign pl_off = pos_reg - PAYLOAD_FIRST;
    assign pl_idx = pl_off[2:0];

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        hdr_ok_next = hdr_ok_reg;
        cmd_next    = cmd_reg;
        gain_next   = gain_reg;
        ret_next    = ret_reg;
        pl_wr       = 1'b0;
        frame_ok    = 1'b0;
        if (step)
        begin
            if (!frame_end)
            begin
                sum_next = sum_reg + rx_byte;
                if (pos_reg == 8'd0 && rx_byte != HDR0)
                    hdr_ok_next = 1'b0;
                if (pos_reg == 8'd1 && rx_byte != HDR1)
                    hdr_ok_next = 1'b0;
                if (pos_reg == 8'd2)
                    cmd_next = rx_byte;
                pl_wr = pos_reg inside {[8'd4:8'd9]};
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + 8'd1;
            end
            else
            begin
                frame_ok = (pos_reg >= MIN_END_POS) && hdr_ok_reg && (sum_reg == rx_byte);
                if (frame_ok && cmd_reg == CMD_GAINS && pos_reg >= GAIN_END_POS)
                begin
                    for (int k = 0; k < NUM_GAINS; k++)
                        gain_next[k] = {payload_reg[2*k], payload_reg[2*k+1]};
                end
                if (frame_ok && cmd_reg == CMD_RETURN)
                    ret_next = 1'b1;
                // every frame end starts a fresh frame
                pos_next    = '0;
                sum_next    = '0;
                hdr_ok_next = 1'b1;
                cmd_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            cmd_reg    <= '0;
            for (int k = 0; k < NUM_GAINS; k++)
                gain_reg[k] <= '0;
            ret_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            hdr_ok_reg <= hdr_ok_next;
            cmd_reg    <= cmd_next;
            gain_reg   <= gain_next;
            ret_reg    <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pl_wr)
            payload_reg[pl_idx] <= rx_byte;
    end

    assign ack_fire = frame_ok;

    always_comb
    begin
        ack_req.rx_sum         = sum_reg;
        ack_req.prop_gain      = gain_next[0];
        ack_req.integ_gain     = gain_next[1];
        ack_req.deriv_gain     = gain_next[2];
        ack_req.return_request = ret_next;
    end

endmodule

/* rtl/cfr_ack_tx.sv */
`timescale 1ns / 1ps
// acknowledge sender: holds one request and plays out its eight bytes
// depends on cfr_pkg

module cfr_ack_tx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cfr_pkg::ack_req_t  req,
    output logic               free,
    output logic               ack_valid,
    input  logic               ack_ready,
    output cfr_pkg::ack_item_t ack_item
);
    import cfr_pkg::*;

    logic     active_reg, active_next;
    ack_idx_t idx_reg, idx_next;
    ack_req_t req_reg;
    logic     is_last;
    logic     take;

    assign is_last = (idx_reg == ACK_LAST_IDX);
    assign take    = active_reg && ack_ready;
    // free again in the cycle the last byte goes out
    assign free    = !active_reg || (take && is_last);

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (take)
        begin
            if (is_last)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            req_reg <= req;
    end

    assign ack_valid = active_reg;

    always_comb
    begin
        ack_item.tx_byte        = ack_byte(idx_reg, req_reg.rx_sum);
        ack_item.tx_last        = is_last;
        ack_item.prop_gain      = req_reg.prop_gain;
        ack_item.integ_gain     = req_reg.integ_gain;
        ack_item.deriv_gain     = req_reg.deriv_gain;
        ack_item.return_request = req_reg.return_request;
    end

endmodule

/* tb/command_frame_receiver_with_ack_unit_test.sv */
`timescale 1ns / 1ps
// testbench for command_frame_receiver_with_ack_unit: random and directed frames in,
// acknowledge bytes checked against a scoreboard that predicts them
// depends on cfr_pkg and the rtl of the block

module command_frame_receiver_with_ack_unit_test;

    import cfr_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int RANDOM_ITEMS = 185;
    localparam int HOLD_CYCLES  = 300;
    localparam int LONG_BODY    = 260;

    class ack_scoreboard;
        ack_item_t          expected_acks[$];
        int                 errors;
        logic [7:0]         pos;
        logic [7:0]         sum;
        logic [7:0]         cmd;
        bit                 hdr_ok;
        logic [7:0]         payload [PAYLOAD_LEN];
        logic signed [15:0] gains [NUM_GAINS];
        bit                 ret_flag;

        function new();
            errors   = 0;
            ret_flag = 0;
            foreach (payload[i]) payload[i] = 8'h00;
            foreach (gains[i]) gains[i] = 16'sd0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos    = 8'd0;
            sum    = 8'd0;
            cmd    = 8'd0;
            hdr_ok = 1;
        endfunction

        // predicts the acknowledge bytes caused by one accepted request
        function void note_rx(rx_item_t it);
            logic [7:0] ack [8];
            logic [7:0] trailer;
            ack_item_t  a;
            if (!it.frame_end)
            begin
                sum = sum + it.rx_byte;
                if (pos == 8'd0 && it.rx_byte != HDR0) hdr_ok = 0;
                if (pos == 8'd1 && it.rx_byte != HDR1) hdr_ok = 0;
                if (pos == 8'd2) cmd = it.rx_byte;
                if (pos >= PAYLOAD_FIRST && pos < PAYLOAD_FIRST + PAYLOAD_LEN)
                    payload[pos - PAYLOAD_FIRST] = it.rx_byte;
                if (pos != POS_MAX) pos = pos + 8'd1;
                return;
            end
            if (pos < MIN_END_POS || !hdr_ok || sum != it.rx_byte)
            begin
                clear_frame();
                return;
            end
            // gains need all six payload bytes from this frame
            if (cmd == CMD_GAINS && pos >= GAIN_END_POS)
            begin
                for (int k = 0; k < NUM_GAINS; k++)
                    gains[k] = {payload[2 * k], payload[2 * k + 1]};
            end
            if (cmd == CMD_RETURN) ret_flag = 1;
            ack[0] = HDR0;
            ack[1] = HDR0;
            ack[2] = ACK_ID;
            ack[3] = ACK_LEN;
            ack[4] = ACK_TAG;
            ack[5] = ACK_PAD;
            ack[6] = sum;
            trailer = 8'h00;
            for (int k = 0; k < 7; k++) trailer = trailer + ack[k];
            ack[7] = trailer;
            for (int k = 0; k < 8; k++)
            begin
                a.tx_byte        = ack[k];
                a.tx_last        = (k == 7);
                a.prop_gain      = gains[0];
                a.integ_gain     = gains[1];
                a.deriv_gain     = gains[2];
                a.return_request = ret_flag;
                expected_acks.push_back(a);
            end
            clear_frame();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_ack(ack_item_t got);
            ack_item_t want;
            if (expected_acks.size() == 0)
            begin
                $display("%0t: unexpected ack byte, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_acks.pop_front();
            compare_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
            compare_field("tx_last", 16'(want.tx_last), 16'(got.tx_last));
            compare_field("prop_gain", want.prop_gain, got.prop_gain);
            compare_field("integ_gain", want.integ_gain, got.integ_gain);
            compare_field("deriv_gain", want.deriv_gain, got.deriv_gain);
            compare_field("return_request", 16'(want.return_request),
                          16'(got.return_request));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      rx_valid;
    logic      rx_ready;
    rx_item_t  rx_item;
    logic      ack_valid;
    logic      ack_ready;
    ack_item_t ack_item;

    ack_scoreboard sb;
    bit            quiet;
    bit            hold_asked;

    command_frame_receiver_with_ack_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_item  (rx_item),
        .ack_valid(ack_valid),
        .ack_ready(ack_ready),
        .ack_item (ack_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_rx(input logic [7:0] b, input logic last);
        rx_item_t it;
        it.rx_byte   = b;
        it.frame_end = last;
        while (!quiet && $urandom_range(99) < 30)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_item  <= it;
        do
            @(posedge clk);
        while (!rx_ready);
        sb.note_rx(it);
        @(negedge clk);
    endtask

    // body bytes, then the checksum byte with some bits optionally flipped
    task automatic send_frame(input byte_q_t body, input logic [7:0] cs_flip);
        logic [7:0] cs;
        cs = 8'h00;
        foreach (body[i])
        begin
            cs = cs + body[i];
            send_rx(body[i], 1'b0);
        end
        send_rx(cs ^ cs_flip, 1'b1);
    endtask

    function automatic byte_q_t frame_body(input logic [7:0] cmd, input int len);
        byte_q_t q;
        q = {HDR0, HDR1, cmd};
        while (q.size() < len) q.push_back(8'($urandom));
        while (q.size() > len) void'(q.pop_back());
        return q;
    endfunction

    // sends one random frame and returns how many requests it took
    task automatic send_random_frame(output int count);
        int      kind;
        int      n;
        byte_q_t body;
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            body = frame_body(CMD_GAINS, $urandom_range(15, 10));
        end
        else if (kind < 32)
        begin
            // gain command too short to carry all three gains
            body = frame_body(CMD_GAINS, $urandom_range(9, 4));
        end
        else if (kind < 47)
        begin
            body = frame_body(CMD_RETURN, $urandom_range(14, 4));
        end
        else if (kind < 70)
        begin
            body = frame_body(8'($urandom), $urandom_range(14, 4));
        end
        else if (kind < 78)
        begin
            body = frame_body(8'($urandom), $urandom_range(12, 4));
            n = $urandom_range(1);
            body[n] = body[n] ^ 8'($urandom_range(255, 1));
        end
        else if (kind < 92)
        begin
            body = frame_body(8'($urandom), (kind < 86) ? $urandom_range(12, 4)
                                                       : $urandom_range(3, 0));
        end
        else
        begin
            // noise, resynchronized by a closing frame_end byte
            n = $urandom_range(12, 1);
            for (int i = 0; i < n; i++)
                send_rx(8'($urandom), $urandom_range(99) < 15);
            send_rx(8'($urandom), 1'b1);
            count = n + 1;
            return;
        end
        count = body.size() + 1;
        send_frame(body, (kind >= 78 && kind < 86) ? 8'($urandom_range(255, 1)) : 8'h00);
    endtask

    // receiver side: checks accepted bytes, randomizes ready, one long hold-off
    initial
    begin
        int hold_left;
        bit hold_served;
        hold_left   = 0;
        hold_served = 0;
        ack_ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (ack_valid && ack_ready) sb.check_ack(ack_item);
            @(negedge clk);
            if (hold_asked && !hold_served)
            begin
                hold_served = 1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ack_ready <= 1'b0;
            end
            else
            begin
                ack_ready <= quiet || ($urandom_range(99) >= 30);
            end
        end
    end

    initial
    begin
        int      rand_sent;
        int      count;
        byte_q_t body;
        sb         = new();
        quiet      = 0;
        hold_asked = 0;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_item    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // shortest good frame, return command, byte of all ones
        send_frame({HDR0, HDR1, CMD_RETURN, 8'hFF}, 8'h00);
        // gain frame with extreme gains and a zero byte
        send_frame({HDR0, HDR1, CMD_GAINS, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF,
                    8'hFF, 8'hFF}, 8'h00);
        // four bytes is one too short
        send_frame({HDR0, HDR1, CMD_GAINS}, 8'h00);
        // unknown command, acknowledged only
        send_frame({HDR0, HDR1, 8'h55, 8'h00}, 8'h00);

        // frame long enough to saturate the position counter
        send_frame(frame_body(CMD_GAINS, LONG_BODY), 8'h00);

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            quiet = (rand_sent >= 40 && rand_sent < 110);
            if (rand_sent >= 120) hold_asked = 1;
            send_random_frame(count);
            rand_sent += count;
        end
        quiet = 0;
        rx_valid <= 1'b0;

        while (sb.expected_acks.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cfr_pkg.sv
rtl/cfr_frame.sv
rtl/cfr_ack_tx.sv
rtl/command_frame_receiver_with_ack_unit.sv
tb/command_frame_receiver_with_ack_unit_test.sv
